// File: rtl/core/balu_pkg.sv
`timescale 1ns / 1ps

package balu_pkg;

	localparam int CMD_W  = 4;
	localparam int BYTE_W = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_OR   = 4'd0,
		CMD_AND  = 4'd1,
		CMD_XOR  = 4'd2,
		CMD_ADC  = 4'd3,
		CMD_SBC  = 4'd4,
		CMD_CMP  = 4'd5,
		CMD_BIT  = 4'd6,
		CMD_ASL  = 4'd7,
		CMD_LSR  = 4'd8,
		CMD_ROL  = 4'd9,
		CMD_ROR  = 4'd10,
		CMD_INC  = 4'd11,
		CMD_DEC  = 4'd12,
		CMD_LOAD = 4'd13
	} cmd_t;

	localparam int FLAG_C = 0;
	localparam int FLAG_Z = 1;
	localparam int FLAG_D = 3;
	localparam int FLAG_U = 5;
	localparam int FLAG_V = 6;
	localparam int FLAG_N = 7;

	localparam logic [4:0] BCD_LO_LIMIT = 5'h0A;
	localparam logic [3:0] BCD_LO_FIX   = 4'h6;
	localparam logic [8:0] BCD_HI_LIMIT = 9'h0A0;
	localparam logic [9:0] BCD_HI_FIX   = 10'h060;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [BYTE_W-1:0] reg_in;
		logic [BYTE_W-1:0] mem_in;
		logic [BYTE_W-1:0] status_in;
	} alu_in_t;

	typedef struct packed {
		logic [BYTE_W-1:0] result;
		logic [BYTE_W-1:0] status_out;
	} alu_out_t;

	typedef struct packed {
		logic n;
		logic v;
		logic z;
		logic c;
	} nzvc_t;

endpackage

// File: rtl/core/balu_ifs.sv
`timescale 1ns / 1ps

interface balu_req_if import balu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [BYTE_W-1:0] reg_in;
	logic [BYTE_W-1:0] mem_in;
	logic [BYTE_W-1:0] status_in;

	modport source (output valid, cmd, reg_in, mem_in, status_in, input ready);
	modport sink (input valid, cmd, reg_in, mem_in, status_in, output ready);
endinterface

interface balu_rsp_if import balu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] result;
	logic [BYTE_W-1:0] status_out;

	modport source (output valid, result, status_out, input ready);
	modport sink (input valid, result, status_out, output ready);
endinterface

// File: rtl/core/balu_addsub.sv
`timescale 1ns / 1ps

module balu_addsub import balu_pkg::*; (
	input  logic              sub,
	input  logic              dec,
	input  logic [BYTE_W-1:0] a,
	input  logic [BYTE_W-1:0] b,
	input  logic              cin,
	output logic [BYTE_W-1:0] sum,
	output nzvc_t             flags
);

	logic [8:0] bin_add;
	logic [4:0] lo_add;
	logic [4:0] lo_add_fix;
	logic [8:0] hi_add;
	logic [9:0] hi_add_fix;
	logic       borrow;
	logic [8:0] bin_sub;
	logic [5:0] lo_sub;
	logic [5:0] lo_sub_dec;
	logic [5:0] lo_sub_fix;
	logic [9:0] hi_sub;
	logic [9:0] hi_sub_fix;

	assign bin_add    = {1'b0, a} + {1'b0, b} + {8'b0, cin};
	assign lo_add     = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, cin};
	assign lo_add_fix = (lo_add >= BCD_LO_LIMIT) ? {1'b1, lo_add[3:0] + BCD_LO_FIX} : lo_add;
	assign hi_add     = {1'b0, a[7:4], 4'b0} + {1'b0, b[7:4], 4'b0} + {4'b0, lo_add_fix};
	assign hi_add_fix = (hi_add >= BCD_HI_LIMIT) ? {1'b0, hi_add} + BCD_HI_FIX
			: {1'b0, hi_add};

	assign borrow     = ~cin;
	assign bin_sub    = {1'b0, a} - {1'b0, b} - {8'b0, borrow};
	assign lo_sub     = {2'b0, a[3:0]} - {2'b0, b[3:0]} - {5'b0, borrow};
	assign lo_sub_dec = lo_sub - {2'b0, BCD_LO_FIX};
	assign lo_sub_fix = lo_sub[5] ? {2'b11, lo_sub_dec[3:0]} : lo_sub;
	assign hi_sub     = {2'b0, a[7:4], 4'b0} - {2'b0, b[7:4], 4'b0}
			+ {{4{lo_sub_fix[5]}}, lo_sub_fix};
	assign hi_sub_fix = hi_sub[9] ? hi_sub - BCD_HI_FIX : hi_sub;

	always_comb begin
		if (sub) begin
			flags.c = ~bin_sub[8];
			flags.v = (a[7] ^ b[7]) & (a[7] ^ bin_sub[7]);
			flags.z = (bin_sub[7:0] == '0);
			flags.n = bin_sub[7];
			sum     = dec ? hi_sub_fix[7:0] : bin_sub[7:0];
		end else if (dec) begin
			flags.c = |hi_add_fix[9:8];
			flags.v = ~(a[7] ^ b[7]) & (a[7] ^ hi_add[7]);
			flags.z = (bin_add[7:0] == '0);
			flags.n = hi_add[7];
			sum     = hi_add_fix[7:0];
		end else begin
			flags.c = bin_add[8];
			flags.v = ~(a[7] ^ b[7]) & (a[7] ^ bin_add[7]);
			flags.z = (bin_add[7:0] == '0);
			flags.n = bin_add[7];
			sum     = bin_add[7:0];
		end
	end

endmodule

// File: rtl/core/balu_exec.sv
`timescale 1ns / 1ps

module balu_exec import balu_pkg::*; (
	input  alu_in_t  op,
	output alu_out_t res
);

	logic [BYTE_W-1:0] as_sum;
	nzvc_t             as_flags;
	logic [BYTE_W-1:0] cmp_diff;
	logic [BYTE_W-1:0] r;
	logic [BYTE_W-1:0] p;

	function automatic logic [BYTE_W-1:0] put_nz(input logic [BYTE_W-1:0] st,
			input logic [BYTE_W-1:0] val);
		logic [BYTE_W-1:0] o;
		o         = st;
		o[FLAG_Z] = (val == '0);
		o[FLAG_N] = val[BYTE_W-1];
		return o;
	endfunction

	balu_addsub u_addsub (
		.sub   (op.cmd == CMD_SBC),
		.dec   (op.status_in[FLAG_D]),
		.a     (op.reg_in),
		.b     (op.mem_in),
		.cin   (op.status_in[FLAG_C]),
		.sum   (as_sum),
		.flags (as_flags)
	);

	assign cmp_diff = op.reg_in - op.mem_in;

	always_comb begin
		r = op.reg_in;
		p = op.status_in;
		unique case (op.cmd)
			CMD_OR: begin
				r = op.reg_in | op.mem_in;
				p = put_nz(p, r);
			end
			CMD_AND: begin
				r = op.reg_in & op.mem_in;
				p = put_nz(p, r);
			end
			CMD_XOR: begin
				r = op.reg_in ^ op.mem_in;
				p = put_nz(p, r);
			end
			CMD_ADC, CMD_SBC: begin
				r         = as_sum;
				p[FLAG_C] = as_flags.c;
				p[FLAG_Z] = as_flags.z;
				p[FLAG_V] = as_flags.v;
				p[FLAG_N] = as_flags.n;
			end
			CMD_CMP: begin
				p         = put_nz(p, cmp_diff);
				p[FLAG_C] = (op.reg_in >= op.mem_in);
			end
			CMD_BIT: begin
				p[FLAG_Z] = ((op.reg_in & op.mem_in) == '0);
				p[FLAG_N] = op.mem_in[7];
				p[FLAG_V] = op.mem_in[6];
			end
			CMD_ASL: begin
				r         = {op.mem_in[6:0], 1'b0};
				p         = put_nz(p, r);
				p[FLAG_C] = op.mem_in[7];
			end
			CMD_LSR: begin
				r         = {1'b0, op.mem_in[7:1]};
				p         = put_nz(p, r);
				p[FLAG_C] = op.mem_in[0];
			end
			CMD_ROL: begin
				r         = {op.mem_in[6:0], op.status_in[FLAG_C]};
				p         = put_nz(p, r);
				p[FLAG_C] = op.mem_in[7];
			end
			CMD_ROR: begin
				r         = {op.status_in[FLAG_C], op.mem_in[7:1]};
				p         = put_nz(p, r);
				p[FLAG_C] = op.mem_in[0];
			end
			CMD_INC: begin
				r = op.mem_in + 8'd1;
				p = put_nz(p, r);
			end
			CMD_DEC: begin
				r = op.mem_in - 8'd1;
				p = put_nz(p, r);
			end
			CMD_LOAD: begin
				r = op.mem_in;
				p = put_nz(p, r);
			end
			default: begin
				r = op.reg_in;
			end
		endcase
		p[FLAG_U] = 1'b1;
	end

	assign res.result     = r;
	assign res.status_out = p;

endmodule

// File: rtl/core/byte_alu_with_bcd_mode.sv
`timescale 1ns / 1ps
// Channel | Role   | Payload
// --------+--------+--------------------------------------
// req     | sink   | cmd, reg_in, mem_in, status_in
// rsp     | source | result, status_out
//
// One transaction per cycle sustained while rsp is not stalled.
// Input register feeds the ALU logic, whose output is held in the result register.
// arst_n clears both valid bits; payload registers are not reset.
// A stall on rsp holds the result register; req is accepted while the input stage is empty or can drain.

module byte_alu_with_bcd_mode import balu_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	balu_req_if.sink   req,
	balu_rsp_if.source rsp
);

	logic     valid_s1;
	alu_in_t  in_s1;
	logic     valid_s2;
	alu_out_t out_s2;
	alu_out_t exec_res;
	logic     load_s2;
	logic     take_req;

	assign load_s2   = ~valid_s2 | rsp.ready;
	assign req.ready = ~valid_s1 | load_s2;
	assign take_req  = req.valid & req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_req) begin
			in_s1 <= '{cmd: req.cmd, reg_in: req.reg_in, mem_in: req.mem_in,
					status_in: req.status_in};
		end
	end

	balu_exec u_exec (
		.op  (in_s1),
		.res (exec_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			out_s2 <= exec_res;
		end
	end

	assign rsp.valid      = valid_s2;
	assign rsp.result     = out_s2.result;
	assign rsp.status_out = out_s2.status_out;

endmodule

// File: rtl/core/balu_chk.sv
`timescale 1ns / 1ps

module balu_chk import balu_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [BYTE_W-1:0] rsp_status_out
);

	// unused status bit reads as set on every result
	a_unused_bit_set: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status_out[FLAG_U])
		else $error("status_out unused bit clear");

	// an empty result register never blocks the request side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("req stalled with empty result stage");

	// an accepted transaction passes through the input and result registers to rsp when the sink drains
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) ##1 rsp_ready |=> rsp_valid)
		else $error("accepted transaction did not reach rsp");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status_out))
		else $error("stalled rsp dropped or changed");

endmodule

bind byte_alu_with_bcd_mode balu_chk u_balu_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status_out (rsp.status_out)
);
